// ===== rtl/sbsd_pkg.sv =====
package sbsd_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int SIZE_W      = 31;
   localparam int GAIN_W      = 32;
   localparam int CSR_IDX_W   = 2;

   localparam int AXES  = 3;
   localparam int FACES = 2 * AXES;

   // face distances carry one extra fraction bit
   localparam int H_W      = COORD_WIDTH + 4;
   localparam int MAG_W    = H_W;
   localparam int MAG_LO_W = MAG_W / 2;
   localparam int MAG_HI_W = MAG_W - MAG_LO_W;
   localparam int PP_W     = MAG_HI_W + GAIN_W;
   localparam int P_SUM_W  = MAG_W + GAIN_W;

   localparam int QI      = 30;
   localparam int P_W     = 2 * FRAC_BITS + 6;
   localparam int P_SHIFT = P_W - QI;
   localparam int SUM_W   = QI + 2;
   localparam int S_W     = QI + 3;
   localparam int ACC_W   = QI + 1;

   localparam int EXP_TERMS = 12;
   localparam int EXP_SQ    = 5;
   localparam int LOG_TERMS = 12;

   localparam int DIV_STEP = 2;
   localparam int D1_ST    = QI / DIV_STEP;
   localparam int LG_W     = 32;
   localparam int LG_SHIFT = 2 * FRAC_BITS + 1 - QI;
   localparam int NUM_W    = LG_W + LG_SHIFT + 1;
   localparam int D2_ST    = NUM_W / DIV_STEP;
   localparam int TOT_W    = H_W + 2;

   localparam logic [QI:0]     ONE_QI = (QI + 1)'(1) << QI;
   localparam logic [LG_W-1:0] LN2_QI = LG_W'(744261118);

   localparam int unsigned KAPPA_ROUNDED = ((32'd1 << FRAC_BITS) + 32'd500) / 32'd1000;
   localparam logic [GAIN_W-1:0] KAPPA_FLOOR =
      (KAPPA_ROUNDED != 0) ? GAIN_W'(KAPPA_ROUNDED) : GAIN_W'(1);

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1) << FRAC_BITS;
   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(10) << FRAC_BITS;

   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   localparam logic [CSR_IDX_W-1:0] REG_SIZE_X = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_Y = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_Z = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_GAIN   = CSR_IDX_W'(3);

   // reciprocal multipliers: floor(x/d) = (x*M) >> S for x < 2^QI
   localparam logic [QI:0] EXP_MAGIC [EXP_TERMS] = '{
      31'(((64'd1 << 30) + 64'd0)  / 64'd1),
      31'(((64'd1 << 31) + 64'd1)  / 64'd2),
      31'(((64'd1 << 32) + 64'd2)  / 64'd3),
      31'(((64'd1 << 32) + 64'd3)  / 64'd4),
      31'(((64'd1 << 33) + 64'd4)  / 64'd5),
      31'(((64'd1 << 33) + 64'd5)  / 64'd6),
      31'(((64'd1 << 33) + 64'd6)  / 64'd7),
      31'(((64'd1 << 33) + 64'd7)  / 64'd8),
      31'(((64'd1 << 34) + 64'd8)  / 64'd9),
      31'(((64'd1 << 34) + 64'd9)  / 64'd10),
      31'(((64'd1 << 34) + 64'd10) / 64'd11),
      31'(((64'd1 << 34) + 64'd11) / 64'd12)
   };
   localparam int unsigned EXP_SHIFT [EXP_TERMS] = '{
      30, 31, 32, 32, 33, 33, 33, 33, 34, 34, 34, 34
   };

   localparam logic [QI:0] LOG_MAGIC [LOG_TERMS] = '{
      31'(((64'd1 << 30) + 64'd0)  / 64'd1),
      31'(((64'd1 << 32) + 64'd2)  / 64'd3),
      31'(((64'd1 << 33) + 64'd4)  / 64'd5),
      31'(((64'd1 << 33) + 64'd6)  / 64'd7),
      31'(((64'd1 << 34) + 64'd8)  / 64'd9),
      31'(((64'd1 << 34) + 64'd10) / 64'd11),
      31'(((64'd1 << 34) + 64'd12) / 64'd13),
      31'(((64'd1 << 34) + 64'd14) / 64'd15),
      31'(((64'd1 << 35) + 64'd16) / 64'd17),
      31'(((64'd1 << 35) + 64'd18) / 64'd19),
      31'(((64'd1 << 35) + 64'd20) / 64'd21),
      31'(((64'd1 << 35) + 64'd22) / 64'd23)
   };
   localparam int unsigned LOG_SHIFT [LOG_TERMS] = '{
      30, 32, 33, 33, 34, 34, 34, 34, 35, 35, 35, 35
   };

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic signed [COORD_WIDTH-1:0] point_z;
      logic signed [COORD_WIDTH-1:0] center_x;
      logic signed [COORD_WIDTH-1:0] center_y;
      logic signed [COORD_WIDTH-1:0] center_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] smooth_distance;
      logic                          saturated;
   } rsp_type;

   function automatic logic [QI-1:0] div_magic(input logic [QI-1:0] x,
                                               input logic [QI:0] mgc,
                                               input int unsigned sh);
      logic [2*QI:0] prod;
      prod = x * mgc;
      return QI'(prod >> sh);
   endfunction

endpackage

// ===== rtl/smooth_box_signed_distance_core.sv =====
// Smooth box signed distance, fully pipelined.
// The pipeline carries the exp series, the two shift-subtract dividers and the log series.
// Throughput: one transaction per cycle; the whole pipeline holds while a response waits.
// Reset (synchronous): pipeline valid bits cleared, configuration registers back to defaults.
module smooth_box_signed_distance_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  sbsd_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output sbsd_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sbsd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sbsd_pkg::GAIN_W-1:0]         csr_data
);
   import sbsd_pkg::*;

   localparam int ST_W   = 5;
   localparam int ST_SUM = ST_W + 2 * EXP_TERMS + EXP_SQ + 1;
   localparam int ST_LNP = ST_SUM + 1;
   localparam int ST_Z   = ST_LNP + D1_ST + 1;
   localparam int ST_NUM = ST_Z + LOG_TERMS + 1;
   localparam int LAT    = ST_NUM + D2_ST + 1;

   localparam logic signed [TOT_W-1:0] D_MAX = TOT_W'(COORD_MAX);
   localparam logic signed [TOT_W-1:0] D_MIN = TOT_W'(COORD_MIN);

   logic adv;
   logic vld_ff [1:LAT];

   logic [SIZE_W-1:0] size_ff [AXES];
   logic [SIZE_W-1:0] size_eff [AXES];
   logic [GAIN_W-1:0] gain_ff;
   logic [GAIN_W-1:0] kq_eff;

   logic signed [COORD_WIDTH-1:0] pt [AXES];
   logic signed [COORD_WIDTH-1:0] ct [AXES];
   logic signed [H_W-1:0] h2_in [FACES];
   logic signed [H_W-1:0] h2_ff [FACES];
   logic signed [H_W-1:0] h2b_ff [FACES];
   logic signed [H_W-1:0] hmax_in;
   logic signed [H_W-1:0] hmax_ff [2:LAT-1];
   logic [MAG_W-1:0] mag_ff [FACES];
   logic [PP_W-1:0] ph_ff [FACES];
   logic [PP_W-1:0] pl_ff [FACES];
   logic [FACES-1:0] skip_in;
   logic [FACES-1:0] skip_ff [ST_W:ST_SUM-1];
   logic [QI-1:0] w_in [FACES];

   logic [QI-1:0]           xa_w_in    [1:EXP_TERMS][FACES];
   logic [QI-1:0]           xa_prod_in [1:EXP_TERMS][FACES];
   logic signed [SUM_W-1:0] xa_sum_in  [1:EXP_TERMS][FACES];
   logic [QI-1:0]           xa_w_ff    [1:EXP_TERMS][FACES];
   logic [QI-1:0]           xa_prod_ff [1:EXP_TERMS][FACES];
   logic signed [SUM_W-1:0] xa_sum_ff  [1:EXP_TERMS][FACES];
   logic [QI-1:0]           xb_w_in    [1:EXP_TERMS][FACES];
   logic [QI:0]             xb_term_in [1:EXP_TERMS][FACES];
   logic signed [SUM_W-1:0] xb_sum_in  [1:EXP_TERMS][FACES];
   logic [QI-1:0]           xb_w_ff    [0:EXP_TERMS][FACES];
   logic [QI:0]             xb_term_ff [0:EXP_TERMS][FACES];
   logic signed [SUM_W-1:0] xb_sum_ff  [0:EXP_TERMS][FACES];

   logic [QI:0] sq_in [1:EXP_SQ][FACES];
   logic [QI:0] sq_ff [1:EXP_SQ][FACES];
   logic [S_W-1:0] s_in;
   logic [S_W-1:0] s_ff;

   logic [1:0]  m_in;
   logic [1:0]  m_ff [ST_LNP:ST_NUM-1];
   logic [31:0] d1_rem_in [1:D1_ST];
   logic [31:0] d1_den_in [1:D1_ST];
   logic [QI-1:0] d1_q_in [1:D1_ST];
   logic [31:0] d1_rem_ff [0:D1_ST];
   logic [31:0] d1_den_ff [0:D1_ST];
   logic [QI-1:0] d1_q_ff [0:D1_ST];
   logic [QI-1:0] a_in;
   logic [31:0] den_in;

   logic [QI-1:0] z2_in;
   logic [QI-1:0]    lg_pw_in  [1:LOG_TERMS];
   logic [QI-1:0]    lg_z2_in  [1:LOG_TERMS];
   logic [ACC_W-1:0] lg_acc_in [1:LOG_TERMS];
   logic [QI-1:0]    lg_pw_ff  [0:LOG_TERMS];
   logic [QI-1:0]    lg_z2_ff  [0:LOG_TERMS];
   logic [ACC_W-1:0] lg_acc_ff [0:LOG_TERMS];

   logic [NUM_W-1:0]  num_in;
   logic [GAIN_W-1:0] d2_rem_in [1:D2_ST];
   logic [NUM_W-1:0]  d2_num_in [1:D2_ST];
   logic [NUM_W-1:0]  d2_q_in   [1:D2_ST];
   logic [GAIN_W-1:0] d2_rem_ff [0:D2_ST];
   logic [NUM_W-1:0]  d2_num_ff [0:D2_ST];
   logic [NUM_W-1:0]  d2_q_ff   [0:D2_ST];

   rsp_type out_in;
   rsp_type out_ff;

   assign adv       = !vld_ff[LAT] || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;
   assign rsp_valid = vld_ff[LAT];
   assign rsp_payload = out_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) size_ff[a] <= SIZE_RESET;
         gain_ff <= GAIN_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_SIZE_X: size_ff[0] <= csr_data[SIZE_W-1:0];
            REG_SIZE_Y: size_ff[1] <= csr_data[SIZE_W-1:0];
            REG_SIZE_Z: size_ff[2] <= csr_data[SIZE_W-1:0];
            REG_GAIN:   gain_ff    <= csr_data;
         endcase
      end
   end

   always_comb begin
      for (int a = 0; a < AXES; a++)
         size_eff[a] = (size_ff[a] == '0) ? SIZE_W'(1) : size_ff[a];
      kq_eff = (gain_ff == '0) ? KAPPA_FLOOR : gain_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= LAT; k++) vld_ff[k] <= 1'b0;
      end else if (adv) begin
         vld_ff[1] <= req_valid;
         for (int k = 2; k <= LAT; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // face distances, maximum, offsets and scaling
   always_comb begin
      logic signed [H_W-1:0] dp;
      logic signed [H_W-1:0] sz;
      pt[0] = req_payload.point_x;
      pt[1] = req_payload.point_y;
      pt[2] = req_payload.point_z;
      ct[0] = req_payload.center_x;
      ct[1] = req_payload.center_y;
      ct[2] = req_payload.center_z;
      for (int a = 0; a < AXES; a++) begin
         dp = H_W'(pt[a]) - H_W'(ct[a]);
         sz = signed'(H_W'(size_eff[a]));
         h2_in[2*a]   = (dp <<< 1) - sz;
         h2_in[2*a+1] = -(dp <<< 1) - sz;
      end
   end

   always_comb begin
      hmax_in = h2_ff[0];
      for (int f = 1; f < FACES; f++)
         if (h2_ff[f] > hmax_in) hmax_in = h2_ff[f];
   end

   always_comb begin
      logic [P_SUM_W-1:0] p;
      for (int f = 0; f < FACES; f++) begin
         p = (P_SUM_W'(ph_ff[f]) << MAG_LO_W) + P_SUM_W'(pl_ff[f]);
         skip_in[f] = |p[P_SUM_W-1:P_W];
         w_in[f]    = p[P_W-1:P_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int f = 0; f < FACES; f++) begin
            h2_ff[f]  <= h2_in[f];
            h2b_ff[f] <= h2_ff[f];
            mag_ff[f] <= MAG_W'(hmax_ff[2] - h2b_ff[f]);
            ph_ff[f]  <= mag_ff[f][MAG_W-1:MAG_LO_W] * kq_eff;
            pl_ff[f]  <= mag_ff[f][MAG_LO_W-1:0] * kq_eff;
         end
         hmax_ff[2] <= hmax_in;
         for (int k = 3; k < LAT; k++) hmax_ff[k] <= hmax_ff[k-1];
         skip_ff[ST_W] <= skip_in;
         for (int k = ST_W + 1; k < ST_SUM; k++) skip_ff[k] <= skip_ff[k-1];
      end
   end

   // exp(-t/32): Taylor series, two stages per term
   always_comb begin
      logic [2*QI:0] tw;
      logic [QI-1:0] t;
      for (int i = 1; i <= EXP_TERMS; i++) begin
         for (int f = 0; f < FACES; f++) begin
            tw = xb_term_ff[i-1][f] * xb_w_ff[i-1][f];
            xa_prod_in[i][f] = tw[2*QI-1:QI];
            xa_w_in[i][f]    = xb_w_ff[i-1][f];
            xa_sum_in[i][f]  = xb_sum_ff[i-1][f];
            t = div_magic(xa_prod_ff[i][f], EXP_MAGIC[i-1], EXP_SHIFT[i-1]);
            xb_term_in[i][f] = (QI + 1)'(t);
            xb_w_in[i][f]    = xa_w_ff[i][f];
            if ((i & 1) != 0)
               xb_sum_in[i][f] = xa_sum_ff[i][f] - signed'(SUM_W'(t));
            else
               xb_sum_in[i][f] = xa_sum_ff[i][f] + signed'(SUM_W'(t));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int f = 0; f < FACES; f++) begin
            xb_w_ff[0][f]    <= w_in[f];
            xb_term_ff[0][f] <= ONE_QI;
            xb_sum_ff[0][f]  <= signed'(SUM_W'(ONE_QI));
         end
         for (int i = 1; i <= EXP_TERMS; i++) begin
            for (int f = 0; f < FACES; f++) begin
               xa_w_ff[i][f]    <= xa_w_in[i][f];
               xa_prod_ff[i][f] <= xa_prod_in[i][f];
               xa_sum_ff[i][f]  <= xa_sum_in[i][f];
               xb_w_ff[i][f]    <= xb_w_in[i][f];
               xb_term_ff[i][f] <= xb_term_in[i][f];
               xb_sum_ff[i][f]  <= xb_sum_in[i][f];
            end
         end
      end
   end

   // squarings, rounded half up
   always_comb begin
      logic [QI:0] e [1:EXP_SQ];
      logic [2*QI+1:0] ee;
      for (int f = 0; f < FACES; f++) begin
         e[1] = (xb_sum_ff[EXP_TERMS][f] < 0) ? '0 : xb_sum_ff[EXP_TERMS][f][QI:0];
         for (int k = 2; k <= EXP_SQ; k++) e[k] = sq_ff[k-1][f];
         for (int k = 1; k <= EXP_SQ; k++) begin
            ee = (e[k] * e[k]) + ((2*QI+2)'(1) << (QI - 1));
            sq_in[k][f] = ee[2*QI:QI];
         end
      end
   end

   always_comb begin
      s_in = '0;
      for (int f = 0; f < FACES; f++)
         if (!skip_ff[ST_SUM-1][f]) s_in = s_in + S_W'(sq_ff[EXP_SQ][f]);
   end

   // range reduction for ln
   always_comb begin
      logic [S_W-1:0] y;
      y = s_ff;
      m_in = '0;
      for (int k = 0; k < 3; k++) begin
         if (y >= (S_W'(ONE_QI) << 1)) begin
            y = y >> 1;
            m_in = m_in + 2'd1;
         end
      end
      a_in   = y[QI-1:0];
      den_in = 32'(y) + 32'(ONE_QI);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 1; k <= EXP_SQ; k++)
            for (int f = 0; f < FACES; f++) sq_ff[k][f] <= sq_in[k][f];
         s_ff <= s_in;
         m_ff[ST_LNP] <= m_in;
         for (int k = ST_LNP + 1; k < ST_NUM; k++) m_ff[k] <= m_ff[k-1];
      end
   end

   // z = (y-1)/(y+1), two quotient bits per stage
   always_comb begin
      logic [32:0] r2;
      logic [31:0] r;
      logic [QI-1:0] q;
      for (int k = 1; k <= D1_ST; k++) begin
         r = d1_rem_ff[k-1];
         q = d1_q_ff[k-1];
         for (int b = 0; b < DIV_STEP; b++) begin
            r2 = {r, 1'b0};
            if (r2 >= {1'b0, d1_den_ff[k-1]}) begin
               r2 = r2 - {1'b0, d1_den_ff[k-1]};
               q = {q[QI-2:0], 1'b1};
            end else begin
               q = {q[QI-2:0], 1'b0};
            end
            r = r2[31:0];
         end
         d1_rem_in[k] = r;
         d1_q_in[k]   = q;
         d1_den_in[k] = d1_den_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d1_rem_ff[0] <= 32'(a_in);
         d1_den_ff[0] <= den_in;
         d1_q_ff[0]   <= '0;
         for (int k = 1; k <= D1_ST; k++) begin
            d1_rem_ff[k] <= d1_rem_in[k];
            d1_den_ff[k] <= d1_den_in[k];
            d1_q_ff[k]   <= d1_q_in[k];
         end
      end
   end

   // atanh series, one term per stage
   always_comb begin
      logic [2*QI-1:0] zz;
      logic [2*QI-1:0] pz;
      zz = d1_q_ff[D1_ST] * d1_q_ff[D1_ST];
      z2_in = zz[2*QI-1:QI];
      for (int i = 1; i <= LOG_TERMS; i++) begin
         pz = lg_pw_ff[i-1] * lg_z2_ff[i-1];
         lg_pw_in[i]  = pz[2*QI-1:QI];
         lg_z2_in[i]  = lg_z2_ff[i-1];
         lg_acc_in[i] = lg_acc_ff[i-1] +
            ACC_W'(div_magic(lg_pw_ff[i-1], LOG_MAGIC[i-1], LOG_SHIFT[i-1]));
      end
   end

   always_comb begin
      logic [LG_W-1:0] lg;
      lg = (LG_W'(m_ff[ST_NUM-1]) * LN2_QI) + {lg_acc_ff[LOG_TERMS], 1'b0};
      num_in = (NUM_W'(lg) << LG_SHIFT) + NUM_W'(kq_eff >> 1);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lg_pw_ff[0]  <= d1_q_ff[D1_ST];
         lg_z2_ff[0]  <= z2_in;
         lg_acc_ff[0] <= '0;
         for (int i = 1; i <= LOG_TERMS; i++) begin
            lg_pw_ff[i]  <= lg_pw_in[i];
            lg_z2_ff[i]  <= lg_z2_in[i];
            lg_acc_ff[i] <= lg_acc_in[i];
         end
      end
   end

   // ln S / kappa, two quotient bits per stage
   always_comb begin
      logic [GAIN_W:0]   r2;
      logic [GAIN_W-1:0] r;
      logic [NUM_W-1:0]  n;
      logic [NUM_W-1:0]  q;
      for (int k = 1; k <= D2_ST; k++) begin
         r = d2_rem_ff[k-1];
         n = d2_num_ff[k-1];
         q = d2_q_ff[k-1];
         for (int b = 0; b < DIV_STEP; b++) begin
            r2 = {r, n[NUM_W-1]};
            n  = n << 1;
            if (r2 >= {1'b0, kq_eff}) begin
               r2 = r2 - {1'b0, kq_eff};
               q = {q[NUM_W-2:0], 1'b1};
            end else begin
               q = {q[NUM_W-2:0], 1'b0};
            end
            r = r2[GAIN_W-1:0];
         end
         d2_rem_in[k] = r;
         d2_num_in[k] = n;
         d2_q_in[k]   = q;
      end
   end

   always_comb begin
      logic signed [TOT_W-1:0] total2;
      logic signed [TOT_W-1:0] d_full;
      total2 = TOT_W'(hmax_ff[LAT-1]) + signed'(TOT_W'(d2_q_ff[D2_ST]));
      d_full = (total2 + signed'(TOT_W'(1))) >>> 1;
      if (d_full > D_MAX) begin
         out_in.smooth_distance = COORD_MAX;
         out_in.saturated = 1'b1;
      end else if (d_full < D_MIN) begin
         out_in.smooth_distance = COORD_MIN;
         out_in.saturated = 1'b1;
      end else begin
         out_in.smooth_distance = d_full[COORD_WIDTH-1:0];
         out_in.saturated = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d2_rem_ff[0] <= '0;
         d2_num_ff[0] <= num_in;
         d2_q_ff[0]   <= '0;
         for (int k = 1; k <= D2_ST; k++) begin
            d2_rem_ff[k] <= d2_rem_in[k];
            d2_num_ff[k] <= d2_num_in[k];
            d2_q_ff[k]   <= d2_q_in[k];
         end
         out_ff <= out_in;
      end
   end

endmodule

// ===== rtl/sbsd_checker.sv =====
module sbsd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input sbsd_pkg::rsp_type rsp_payload
);
   import sbsd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response transaction changed while stalled");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while pipeline stalled");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.saturated |->
         (rsp_payload.smooth_distance == COORD_MAX) ||
         (rsp_payload.smooth_distance == COORD_MIN))
      else $error("saturated flag without clipped distance");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("response valid straight after reset");

endmodule

bind smooth_box_signed_distance_core sbsd_checker u_sbsd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
